[design/toc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the tour order crossover unit.
package toc_pkg;

	localparam int MAX_CITIES = 64;

	localparam int CITY_W = 6;
	localparam int POS_W = 6;
	localparam int LEN_W = 7;
	localparam int KIND_W = 2;
	localparam int SET_W = 1 << CITY_W;
	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam int PDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_LOAD_FIRST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_TOUR_LENGTH = 1'b0;

	localparam logic [LEN_W-1:0] TOUR_LENGTH_RESET = 7'd64;
	localparam logic [LEN_W-1:0] MIN_LENGTH = 7'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  position;
		logic [CITY_W-1:0] city;
		logic [POS_W-1:0]  seg_first;
		logic [POS_W-1:0]  seg_second;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]  child_position;
		logic [CITY_W-1:0] child_city;
		logic              last;
	} result_t;

endpackage

[design/toc_tour_mem.sv]
`timescale 1ns / 1ps
// Parent tour store with one write port and one registered read port.
module toc_tour_mem #(
	parameter int MaxCities = toc_pkg::MAX_CITIES
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(MaxCities)-1:0]        wr_addr,
	input  logic [toc_pkg::CITY_W-1:0]          wr_city,
	input  logic [$clog2(MaxCities)-1:0]        rd_addr,
	output logic [toc_pkg::CITY_W-1:0]          rd_city
);

	logic [toc_pkg::CITY_W-1:0] mem_q [MaxCities];
	logic [toc_pkg::CITY_W-1:0] rd_city_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_city;
		end
		rd_city_q <= mem_q[rd_addr];
	end

	assign rd_city = rd_city_q;

endmodule

[design/toc_seq.sv]
`timescale 1ns / 1ps
// Sequencer that builds the segment set and walks both parent stores to emit the child.
module toc_seq #(
	parameter int MaxCities = toc_pkg::MAX_CITIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              run,
	input  logic [toc_pkg::POS_W-1:0]         seg_first,
	input  logic [toc_pkg::POS_W-1:0]         seg_second,
	input  logic [toc_pkg::LEN_W-1:0]         len,
	input  logic [toc_pkg::CITY_W-1:0]        fp_city,
	input  logic [toc_pkg::CITY_W-1:0]        sp_city,
	output logic [$clog2(MaxCities)-1:0]      fp_addr,
	output logic [$clog2(MaxCities)-1:0]      sp_addr,
	output logic                              busy,
	output logic                              result_valid,
	output toc_pkg::result_t                  result
);

	localparam int AddrW = $clog2(MaxCities);
	localparam int LenW = toc_pkg::LEN_W;
	localparam int SetW = toc_pkg::SET_W;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SET       = 3'd1;
	localparam logic [2:0] ST_SET_END   = 3'd2;
	localparam logic [2:0] ST_FILL_WAIT = 3'd3;
	localparam logic [2:0] ST_FILL_CHK  = 3'd4;

	logic [2:0]                     state_q;
	logic [LenW-1:0]                i_q;
	logic [LenW-1:0]                j_q;
	logic [LenW-1:0]                hi_q;
	logic [SetW-1:0]                set_q;
	logic                           set_vld_q;
	logic                           result_valid_q;
	toc_pkg::result_t               result_q;

	logic [LenW-1:0]                lim;
	logic [LenW-1:0]                bound_a;
	logic [LenW-1:0]                bound_b;
	logic [LenW-1:0]                seg_lo;
	logic [LenW-1:0]                seg_hi;
	logic                           fp_in;
	logic                           sp_in;
	logic                           j_end;
	logic                           emit;
	logic                           at_last;
	logic [toc_pkg::CITY_W-1:0]     fill_city;

	always_comb begin
		lim = len - LenW'(1);
		bound_a = ({1'b0, seg_first} > lim) ? lim : {1'b0, seg_first};
		bound_b = ({1'b0, seg_second} > lim) ? lim : {1'b0, seg_second};
		seg_lo = (bound_a > bound_b) ? bound_b : bound_a;
		seg_hi = (bound_a > bound_b) ? bound_a : bound_b;
		fp_in = set_q[fp_city];
		sp_in = set_q[sp_city];
		j_end = (j_q >= len);
		emit = fp_in || j_end || !sp_in;
		at_last = (i_q == lim);
		if (fp_in) begin
			fill_city = fp_city;
		end else if (j_end) begin
			fill_city = '0;
		end else begin
			fill_city = sp_city;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			hi_q <= '0;
			set_q <= '0;
			set_vld_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (run) begin
						i_q <= seg_lo;
						hi_q <= seg_hi;
						set_q <= '0;
						set_vld_q <= 1'b0;
						state_q <= ST_SET;
					end
				end
				ST_SET: begin
					if (set_vld_q) begin
						set_q <= set_q | (SetW'(1) << fp_city);
					end
					set_vld_q <= 1'b1;
					if (i_q == hi_q) begin
						state_q <= ST_SET_END;
					end else begin
						i_q <= i_q + LenW'(1);
					end
				end
				ST_SET_END: begin
					set_q <= set_q | (SetW'(1) << fp_city);
					i_q <= '0;
					j_q <= '0;
					state_q <= ST_FILL_WAIT;
				end
				ST_FILL_WAIT: begin
					state_q <= ST_FILL_CHK;
				end
				ST_FILL_CHK: begin
					if (!fp_in && !j_end) begin
						j_q <= j_q + LenW'(1);
					end
					if (emit) begin
						result_valid_q <= 1'b1;
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + LenW'(1);
							state_q <= ST_FILL_WAIT;
						end
					end else begin
						state_q <= ST_FILL_WAIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL_CHK && emit) begin
			result_q.child_position <= i_q[toc_pkg::POS_W-1:0];
			result_q.child_city <= fill_city;
			result_q.last <= at_last;
		end
	end

	assign fp_addr = i_q[AddrW-1:0];
	assign sp_addr = j_q[AddrW-1:0];
	assign busy = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

[design/tour_order_crossover_unit.sv]
`timescale 1ns / 1ps
// Top level of the tour order crossover unit.
//
// Channel   Direction  Signals                          Transaction
// command   in         start, busy, item                start high while busy is low
// result    out        result_valid, result             one cycle strobe, no back pressure
// config    in         psel, penable, pwrite, paddr,    APB write, pready always high
//                      pwdata, prdata, pready
//
// A load never raises busy.
// A run first builds the segment set from the first parent store over positions lo to hi,
// then visits each child position in turn, rereading the second parent store for every
// second parent city skipped, all limited by the single read port of each parent store.
// Reset clears the sequencer and sets tour_length to 64; the parent stores are not cleared.
// The result side cannot stall, so each child city appears exactly once on its strobe.
module tour_order_crossover_unit #(
	parameter int MaxCities = toc_pkg::MAX_CITIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  toc_pkg::item_t                    item,
	output logic                              result_valid,
	output toc_pkg::result_t                  result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [toc_pkg::PADDR_W-1:0]       paddr,
	input  logic [toc_pkg::PDATA_W-1:0]       pwdata,
	output logic [toc_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	localparam int AddrW = $clog2(MaxCities);
	localparam int LenW = toc_pkg::LEN_W;

	logic [LenW-1:0]                  tour_length_q;
	logic [LenW-1:0]                  len;
	logic [toc_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                             cfg_wr;
	logic                             accept;
	logic                             pos_ok;
	logic                             fp_wr;
	logic                             sp_wr;
	logic                             run;
	logic [AddrW-1:0]                 fp_addr;
	logic [AddrW-1:0]                 sp_addr;
	logic [toc_pkg::CITY_W-1:0]       fp_city;
	logic [toc_pkg::CITY_W-1:0]       sp_city;

	assign reg_idx = paddr[toc_pkg::PADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tour_length_q <= toc_pkg::TOUR_LENGTH_RESET;
		end else if (cfg_wr && reg_idx == toc_pkg::REG_TOUR_LENGTH) begin
			tour_length_q <= pwdata[LenW-1:0];
		end
	end

	always_comb begin
		if (reg_idx == toc_pkg::REG_TOUR_LENGTH) begin
			prdata = {{(toc_pkg::PDATA_W - LenW){1'b0}}, tour_length_q};
		end else begin
			prdata = '0;
		end
		if (tour_length_q < toc_pkg::MIN_LENGTH) begin
			len = toc_pkg::MIN_LENGTH;
		end else if (tour_length_q > LenW'(MaxCities)) begin
			len = LenW'(MaxCities);
		end else begin
			len = tour_length_q;
		end
	end

	assign accept = start && !busy;
	assign pos_ok = ({1'b0, item.position} < len);
	assign fp_wr = accept && pos_ok && (item.kind == toc_pkg::KIND_LOAD_FIRST);
	assign sp_wr = accept && pos_ok && (item.kind == toc_pkg::KIND_LOAD_SECOND);
	assign run = accept && (item.kind == toc_pkg::KIND_RUN);

	toc_tour_mem #(
		.MaxCities(MaxCities)
	) u_first_parent (
		.clk(clk),
		.wr_en(fp_wr),
		.wr_addr(item.position[AddrW-1:0]),
		.wr_city(item.city),
		.rd_addr(fp_addr),
		.rd_city(fp_city)
	);

	toc_tour_mem #(
		.MaxCities(MaxCities)
	) u_second_parent (
		.clk(clk),
		.wr_en(sp_wr),
		.wr_addr(item.position[AddrW-1:0]),
		.wr_city(item.city),
		.rd_addr(sp_addr),
		.rd_city(sp_city)
	);

	toc_seq #(
		.MaxCities(MaxCities)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.run(run),
		.seg_first(item.seg_first),
		.seg_second(item.seg_second),
		.len(len),
		.fp_city(fp_city),
		.sp_city(sp_city),
		.fp_addr(fp_addr),
		.sp_addr(sp_addr),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("Result strobe without a run in progress.");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("Run still busy after its final position.");

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == toc_pkg::KIND_RUN |=> busy)
		else $error("Accepted run did not start the sequencer.");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind != toc_pkg::KIND_RUN |=> !busy && !result_valid)
		else $error("Load transaction disturbed the sequencer.");

endmodule

[sim/toc_child_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the child tour of every crossover run and compares each emitted city.
module toc_child_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  toc_pkg::item_t                    item,
	input  logic                              result_valid,
	input  toc_pkg::result_t                  result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [toc_pkg::PADDR_W-1:0]       paddr,
	input  logic [toc_pkg::PDATA_W-1:0]       pwdata,
	output int                                errors,
	output int                                pending,
	output int                                checked
);

	localparam int EXPECT_DEPTH = 128;

	logic [toc_pkg::CITY_W-1:0] first_tour [toc_pkg::MAX_CITIES];
	logic [toc_pkg::CITY_W-1:0] second_tour [toc_pkg::MAX_CITIES];
	logic [toc_pkg::LEN_W-1:0]  tour_length;
	logic [toc_pkg::SET_W-1:0]  segment_set;
	toc_pkg::result_t           child_fifo [EXPECT_DEPTH];
	int                         fifo_head;
	int                         fifo_tail;
	int                         fifo_count;
	toc_pkg::result_t           expected_child;

	function automatic int active_length();
		int len;
		len = int'(tour_length);
		if (len < int'(toc_pkg::MIN_LENGTH))
			len = int'(toc_pkg::MIN_LENGTH);
		if (len > toc_pkg::MAX_CITIES)
			len = toc_pkg::MAX_CITIES;
		return len;
	endfunction

	function automatic void predict_child(logic [toc_pkg::POS_W-1:0] bound_a,
			logic [toc_pkg::POS_W-1:0] bound_b);
		int len;
		int lo;
		int hi;
		int tmp;
		int i;
		int j;
		logic [toc_pkg::CITY_W-1:0] c;
		toc_pkg::result_t r;
		len = active_length();
		lo = int'(bound_a);
		hi = int'(bound_b);
		if (lo > len - 1)
			lo = len - 1;
		if (hi > len - 1)
			hi = len - 1;
		if (lo > hi) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		segment_set = '0;
		for (i = lo; i <= hi; i++)
			segment_set[first_tour[i]] = 1'b1;
		j = 0;
		for (i = 0; i < len; i++) begin
			c = first_tour[i];
			if (!segment_set[c]) begin
				while (j < len && segment_set[second_tour[j]])
					j++;
				if (j < len) begin
					c = second_tour[j];
					j++;
				end else begin
					c = '0;
				end
			end
			r.child_position = i[toc_pkg::POS_W-1:0];
			r.child_city = c;
			r.last = (i == len - 1);
			child_fifo[fifo_tail] = r;
			fifo_tail = (fifo_tail + 1) % EXPECT_DEPTH;
			fifo_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tour_length = toc_pkg::TOUR_LENGTH_RESET;
			segment_set = '0;
			fifo_head = 0;
			fifo_tail = 0;
			fifo_count = 0;
			pending = 0;
		end else begin
			if (result_valid) begin
				if (fifo_count == 0) begin
					errors++;
					$display("%0t: unexpected child city: expected none,", $time,
						" got position %0d city %0d last %0b",
						result.child_position, result.child_city, result.last);
				end else begin
					expected_child = child_fifo[fifo_head];
					fifo_head = (fifo_head + 1) % EXPECT_DEPTH;
					fifo_count--;
					checked++;
					if (expected_child.child_position !== result.child_position ||
							expected_child.child_city !== result.child_city ||
							expected_child.last !== result.last) begin
						errors++;
						$display("%0t: child mismatch: expected position %0d city %0d last %0b,",
							$time, expected_child.child_position, expected_child.child_city,
							expected_child.last, " got position %0d city %0d last %0b",
							result.child_position, result.child_city, result.last);
					end
				end
			end
			if (start && !busy) begin
				case (item.kind)
					toc_pkg::KIND_LOAD_FIRST: begin
						if (int'(item.position) < active_length())
							first_tour[item.position] = item.city;
					end
					toc_pkg::KIND_LOAD_SECOND: begin
						if (int'(item.position) < active_length())
							second_tour[item.position] = item.city;
					end
					toc_pkg::KIND_RUN: begin
						predict_child(item.seg_first, item.seg_second);
					end
					default: begin
					end
				endcase
			end
			if (psel && penable && pwrite && pready &&
					paddr[toc_pkg::PADDR_W-1:2] == toc_pkg::REG_TOUR_LENGTH)
				tour_length = pwdata[toc_pkg::LEN_W-1:0];
			pending = fifo_count;
		end
	end

endmodule

[sim/tour_order_crossover_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top that drives parent loads, crossover runs and tour length writes into the unit.
module tour_order_crossover_unit_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [toc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	toc_pkg::item_t                item;
	logic                          result_valid;
	toc_pkg::result_t              result;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [toc_pkg::PADDR_W-1:0]   paddr;
	logic [toc_pkg::PDATA_W-1:0]   pwdata;
	logic [toc_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	int errors;
	int pending;
	int checked;
	int cycles;
	int burst_left;
	int counted_items;
	int sent_items;
	int runs_sent;
	int settings_used;
	int perm_buf [128];
	int first_cities [toc_pkg::MAX_CITIES];
	int second_cities [toc_pkg::MAX_CITIES];

	tour_order_crossover_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	toc_child_checker child_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d child cities outstanding.",
				cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic toc_pkg::item_t make_item(logic [toc_pkg::KIND_W-1:0] kind, int pos,
			int city, int bound_a, int bound_b);
		toc_pkg::item_t it;
		it.kind = kind;
		it.position = pos[toc_pkg::POS_W-1:0];
		it.city = city[toc_pkg::CITY_W-1:0];
		it.seg_first = bound_a[toc_pkg::POS_W-1:0];
		it.seg_second = bound_b[toc_pkg::POS_W-1:0];
		return it;
	endfunction

	function automatic int effective_length(int value);
		int len;
		len = value & 32'h7F;
		if (len < int'(toc_pkg::MIN_LENGTH))
			len = int'(toc_pkg::MIN_LENGTH);
		if (len > toc_pkg::MAX_CITIES)
			len = toc_pkg::MAX_CITIES;
		return len;
	endfunction

	function automatic void shuffle_buf(int n);
		int k;
		int r;
		int tmp;
		for (k = n - 1; k > 0; k--) begin
			r = $urandom_range(0, k);
			tmp = perm_buf[k];
			perm_buf[k] = perm_buf[r];
			perm_buf[r] = tmp;
		end
	endfunction

	function automatic int pick_length(int phase);
		int r;
		case (phase)
			0: return 127;
			1: return 0;
			2: return 1;
			default: begin
			end
		endcase
		r = $urandom_range(0, 7);
		if (r == 0) begin
			case ($urandom_range(0, 5))
				0: return 0;
				1: return 1;
				2: return 2;
				3: return 64;
				4: return 65;
				default: return 127;
			endcase
		end
		if (r == 1)
			return $urandom_range(17, 64);
		return $urandom_range(2, 16);
	endfunction

	task automatic send_item(toc_pkg::item_t it, bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		sent_items++;
		if (it.kind == toc_pkg::KIND_RUN)
			runs_sent++;
		if (counted)
			counted_items++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_tour_length(int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {toc_pkg::REG_TOUR_LENGTH, 2'b00};
		pwdata <= ($urandom() & 32'hFFFF_FF80) | (value & 32'h7F);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	task automatic send_noise(int len);
		if (len < toc_pkg::MAX_CITIES && $urandom_range(0, 1) == 1)
			send_item(make_item($urandom_range(0, 1) == 1 ? toc_pkg::KIND_LOAD_SECOND :
				toc_pkg::KIND_LOAD_FIRST, $urandom_range(len, toc_pkg::MAX_CITIES - 1),
				$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63)), 1'b0);
		else
			send_item(make_item(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 63)), 1'b0);
	endtask

	task automatic send_load(bit second, int pos, int city);
		send_item(make_item(second ? toc_pkg::KIND_LOAD_SECOND : toc_pkg::KIND_LOAD_FIRST, pos,
			city, $urandom_range(0, 63), $urandom_range(0, 63)), 1'b1);
	endtask

	task automatic crossover_phase(int setting);
		int len;
		int k;
		int p;
		int q;
		int tmp;
		int runs;
		int bound_a;
		int bound_b;
		wait_idle();
		write_tour_length(setting);
		len = effective_length(setting);
		for (k = 0; k < toc_pkg::MAX_CITIES; k++)
			perm_buf[k] = k;
		shuffle_buf(toc_pkg::MAX_CITIES);
		for (k = 0; k < len; k++)
			first_cities[k] = perm_buf[k];
		shuffle_buf(len);
		for (k = 0; k < len; k++)
			second_cities[k] = perm_buf[k];
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, len))
				second_cities[$urandom_range(0, len - 1)] = $urandom_range(0, 63);
		end
		for (k = 0; k < 2 * len; k++)
			perm_buf[k] = k;
		shuffle_buf(2 * len);
		for (k = 0; k < 2 * len; k++) begin
			if ($urandom_range(0, 7) == 0)
				send_noise(len);
			p = perm_buf[k] / 2;
			if (perm_buf[k] % 2 == 1)
				send_load(1'b1, p, second_cities[p]);
			else
				send_load(1'b0, p, first_cities[p]);
		end
		runs = $urandom_range(1, 3);
		for (k = 0; k < runs; k++) begin
			if (k > 0 && $urandom_range(0, 1) == 1) begin
				p = $urandom_range(0, len - 1);
				q = $urandom_range(0, len - 1);
				tmp = first_cities[p];
				first_cities[p] = first_cities[q];
				first_cities[q] = tmp;
				send_load(1'b0, p, first_cities[p]);
				send_load(1'b0, q, first_cities[q]);
			end
			if ($urandom_range(0, 1) == 1) begin
				bound_a = $urandom_range(0, 63);
				bound_b = $urandom_range(0, 63);
			end else begin
				bound_a = $urandom_range(0, len - 1);
				bound_b = $urandom_range(0, len - 1);
			end
			send_item(make_item(toc_pkg::KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
				bound_a, bound_b), 1'b1);
		end
	endtask

	initial begin
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		write_tour_length(2);
		send_item(make_item(toc_pkg::KIND_LOAD_FIRST, 0, 63, 63, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_LOAD_FIRST, 1, 0, 0, 63), 1'b0);
		send_item(make_item(toc_pkg::KIND_LOAD_SECOND, 0, 0, 63, 63), 1'b0);
		send_item(make_item(toc_pkg::KIND_LOAD_SECOND, 1, 63, 0, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_RUN, 0, 0, 0, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_RUN, 63, 63, 63, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_RUN, 0, 0, 1, 63), 1'b0);
		send_item(make_item(toc_pkg::KIND_RUN, 63, 63, 63, 63), 1'b0);
		send_item(make_item(toc_pkg::KIND_LOAD_FIRST, 63, 21, 0, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_LOAD_SECOND, 2, 5, 63, 63), 1'b0);
		send_item(make_item(KIND_UNUSED, 63, 63, 63, 63), 1'b0);
		send_item(make_item(KIND_UNUSED, 0, 0, 0, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_RUN, 0, 0, 1, 0), 1'b0);
		// With both second parent cities inside the segment the fill runs dry.
		send_item(make_item(toc_pkg::KIND_LOAD_SECOND, 0, 63, 0, 0), 1'b0);
		send_item(make_item(toc_pkg::KIND_RUN, 0, 0, 0, 0), 1'b0);

		phase = 0;
		while (counted_items < RANDOM_ITEMS) begin
			crossover_phase(pick_length(phase));
			phase++;
		end

		wait_idle();
		repeat (20) @(negedge clk);
		$display("Sent %0d transactions including %0d crossover runs over %0d tour length settings.",
			sent_items, runs_sent, settings_used);
		$display("Checked %0d child cities, with clamped and swapped bounds,", checked,
			" ignored loads and exhausted fills.");
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
